FILE: rtl/mclc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI coherence line controller package
// Shared types, state and action codes, and table sizing for the controller.
// ----------------------------------------------------------------------------
package mclc_pkg;

  // Number of lines in the state table; a power of two, so the line index
  // wraps by dropping its upper bits.
  localparam int NUM_LINES  = 1024;
  localparam int LINE_IDX_W = $clog2(NUM_LINES);

  // Request codes.
  typedef enum logic [3:0] {
    REQ_RD_MISS    = 4'd0,
    REQ_WRITE      = 4'd1,
    REQ_MAKE_DIRTY = 4'd2,
    REQ_PREINVAL   = 4'd3,
    REQ_SNP_RD     = 4'd4,
    REQ_SNP_WR     = 4'd5,
    REQ_SNP_INV    = 4'd6,
    REQ_RD_ACK     = 4'd7,
    REQ_WR_ACK     = 4'd8,
    REQ_INV_ACK    = 4'd9
  } req_e_t;

  // Line states, stable and transient.
  typedef enum logic [3:0] {
    ST_I      = 4'd0,
    ST_S      = 4'd1,
    ST_E      = 4'd2,
    ST_M      = 4'd3,
    ST_RSV    = 4'd4,
    ST_RD     = 4'd5,
    ST_RD_MEM = 4'd6,
    ST_WR     = 4'd7,
    ST_WR_MEM = 4'd8,
    ST_INV    = 4'd9,
    ST_INV_D  = 4'd10
  } line_st_e_t;

  // Response state codes carried by snoops and acks.
  typedef enum logic [1:0] {
    RESP_I = 2'd0,
    RESP_S = 2'd1,
    RESP_E = 2'd2,
    RESP_M = 2'd3
  } resp_e_t;

  // Bus actions.
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RD_MISS  = 3'd1,
    ACT_WR_MISS  = 3'd2,
    ACT_INVAL    = 3'd3,
    ACT_ACK      = 3'd4,
    ACT_RESEND   = 3'd5,
    ACT_CONCLUDE = 3'd6
  } act_e_t;

  // One request item.
  typedef struct packed {
    logic [3:0] req_type;
    logic [9:0] line_index;
    logic [1:0] resp_state;
    logic       resp_found;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] action;
    logic [3:0] new_state;
    logic [1:0] merged_state;
    logic       merged_found;
    logic       is_supplier;
    logic       write_down;
    logic       illegal;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write invalid at the sweep address and advance it
    logic load;    // capture the request and read its line state
    logic exec;    // apply the transition, write back and present the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // sweep address is at the last line
  } dp_stat_t;

endpackage

FILE: rtl/mesi_coherence_line_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI coherence line controller
// Per-line MESI state with transient states, kept in a directly indexed table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_item and raise start; the item is taken at a
//   clock edge where start is high and busy is low.
//   Result channel: out_valid is high for exactly one cycle with out_item;
//   the receiver cannot stall and must take it in that cycle.
//   Timing: the accepting edge reads the line state into a register; the
//   next edge writes the updated state back and loads the result register
//   that drives out_valid and out_item.
//   Items are taken one at a time: busy is high in the cycle after
//   acceptance, while the transition is executed and written back.
//   Reset: rst_n is synchronous, active low. After reset the table is swept
//   to invalid, one line per cycle, through all NUM_LINES (1024) lines;
//   busy stays high during the sweep and no item is taken.
//   A new item may be accepted at the edge that ends the cycle in which the
//   previous result is shown, and it sees that result's state write.
// ----------------------------------------------------------------------------
module mesi_coherence_line_controller
  import mclc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  mclc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table and transition datapath.
  mclc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/mclc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI line controller sequencer
// Runs the table clearing sweep after reset, then steps each item through a
// load step that reads its line state and an execute step.
// ----------------------------------------------------------------------------
module mclc_ctrl
  import mclc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_EXEC
  } ctrl_st_t;

  ctrl_st_t state_r, state_nxt;
  logic     busy_r, busy_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      CS_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != CS_IDLE);
  end

  // State and the registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

FILE: rtl/mclc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI line controller datapath
// Holds the line state table, the captured request, the transition logic and
// the result register.
// ----------------------------------------------------------------------------
module mclc_dp
  import mclc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [3:0]            line_mem [NUM_LINES];
  logic [LINE_IDX_W-1:0] clr_cnt_r;
  logic [3:0]            cur_r;
  in_item_t              req_r;
  logic [LINE_IDX_W-1:0] req_idx;
  out_item_t             res_nxt;
  out_item_t             res_r;
  logic                  out_valid_r;

  // Transition results.
  logic [3:0] nxt;
  logic [2:0] act;
  logic [1:0] mst;
  logic       mfound;
  logic       sup;
  logic       wd;
  logic       bad;
  logic       stable;

  assign req_idx       = req_r.line_index[LINE_IDX_W-1:0];
  assign stat.clr_last = (clr_cnt_r == LINE_IDX_W'(NUM_LINES - 1));

  // Sweep address for the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // State table: one write port (sweep or write-back), one registered read.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      line_mem[clr_cnt_r] <= ST_I;
    end else if (cmd.exec) begin
      line_mem[req_idx] <= nxt;
    end
    if (cmd.load) begin
      cur_r <= line_mem[in_item.line_index[LINE_IDX_W-1:0]];
      req_r <= in_item;
    end
  end

  // Protocol transition for the captured request.
  always_comb begin
    nxt    = cur_r;
    act    = ACT_NONE;
    mst    = RESP_I;
    mfound = 1'b0;
    sup    = 1'b0;
    wd     = 1'b0;
    bad    = 1'b0;
    stable = (cur_r inside {ST_S, ST_E, ST_M});
    case (req_r.req_type)
      REQ_RD_MISS: begin
        if (cur_r == ST_I) begin
          nxt = ST_RD;
          act = ACT_RD_MISS;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (cur_r == ST_S) begin
          nxt = ST_WR;
          act = ACT_INVAL;
        end else if (cur_r == ST_I) begin
          nxt = ST_WR;
          act = ACT_WR_MISS;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_MAKE_DIRTY: begin
        if (stable) begin
          nxt = ST_M;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_PREINVAL: begin
        if (cur_r == ST_M) begin
          nxt = ST_INV_D;
        end else if (cur_r == ST_S || cur_r == ST_E) begin
          nxt = ST_INV;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_SNP_RD, REQ_SNP_WR, REQ_SNP_INV: begin
        // Snoops merge the local state into the response when it is stable.
        mst    = req_r.resp_state;
        mfound = req_r.resp_found;
        act    = ACT_ACK;
        if (stable) begin
          if (cur_r == ST_S) begin
            if (!req_r.resp_found) begin
              mfound = 1'b1;
              sup    = 1'b1;
              mst    = RESP_S;
            end
          end else begin
            mfound = 1'b1;
            sup    = 1'b1;
            mst    = cur_r[1:0];
            wd     = (cur_r == ST_M);
          end
          nxt = (req_r.req_type == REQ_SNP_RD) ? ST_S : ST_I;
        end
      end
      REQ_RD_ACK: begin
        if (req_r.resp_state == RESP_I && cur_r == ST_RD) begin
          nxt = ST_RD_MEM;
          act = ACT_RESEND;
        end else if (req_r.resp_state == RESP_I && cur_r == ST_RD_MEM) begin
          nxt = ST_E;
          act = ACT_CONCLUDE;
        end else if (req_r.resp_state != RESP_I && cur_r == ST_RD) begin
          nxt = ST_S;
          act = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_WR_ACK: begin
        if (req_r.resp_state == RESP_I && cur_r == ST_WR) begin
          nxt = ST_WR_MEM;
          act = ACT_RESEND;
        end else if (cur_r == ST_WR || cur_r == ST_WR_MEM) begin
          nxt = ST_M;
          act = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_INV_ACK: begin
        if (cur_r == ST_WR) begin
          nxt = ST_M;
          act = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // An illegal request keeps the state and issues nothing.
    if (bad) begin
      nxt = cur_r;
      act = ACT_NONE;
    end
    res_nxt.action       = act;
    res_nxt.new_state    = nxt;
    res_nxt.merged_state = mst;
    res_nxt.merged_found = mfound;
    res_nxt.is_supplier  = sup;
    res_nxt.write_down   = wd;
    res_nxt.illegal      = bad;
  end

  // Result register and its strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule

FILE: rtl/mclc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI line controller port checker
// Checks item sequencing and result field consistency at the top level ports.
// ----------------------------------------------------------------------------
module mclc_chk
  import mclc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // Every result comes from an item accepted before its execute step.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching accepted item");

  // An accepted item holds the request side off in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // Results never come in consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high for two cycles");

  // An illegal result issues no bus action.
  a_illegal_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.illegal) |-> (out_item.action == ACT_NONE))
    else $error("illegal result carries a bus action");

  // Merge fields are set only on snoop acknowledgements.
  a_merge_only_snoop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.action != ACT_ACK) |->
      (out_item.merged_found == 1'b0 && out_item.is_supplier == 1'b0 &&
       out_item.write_down == 1'b0 && out_item.merged_state == RESP_I))
    else $error("merge fields set on a non-snoop result");

endmodule

bind mesi_coherence_line_controller mclc_chk u_mclc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: tb/mesi_coherence_line_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI coherence line controller testbench
// Drives a short table of directed requests and then a long stream of random
// requests, most of them legal for the line's current state. A behavioral
// copy of the line state table predicts every result, and each result is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mesi_coherence_line_controller_tb;
  import mclc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RAND_ITEMS   = 1450;
  localparam int POOL_SIZE    = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int MAX_GAP      = 17;
  localparam int DRAIN_LIMIT  = 200;
  localparam int NUM_DIRECTED = 25;

  // Request codes that the block does not define.
  localparam logic [3:0] REQ_UNDEF_LO = 4'd10;
  localparam logic [3:0] REQ_UNDEF_HI = 4'd15;

  // One row of the directed table: request, whether a typed expectation is
  // given, and that expectation.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the coherence table and the results still owed.
  line_st_e_t  shadow_lines [NUM_LINES];
  out_item_t   pending_results [$];
  dir_row_t    dir_rows [NUM_DIRECTED];
  logic [9:0]  hot_lines [POOL_SIZE];

  int unsigned n_errors    = 0;
  int unsigned n_items     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_illegal   = 0;
  int unsigned n_supplied  = 0;
  int unsigned n_writeback = 0;

  mesi_coherence_line_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Computes the result of one request and updates the shadow table.
  function automatic out_item_t apply_coherence(in_item_t req);
    line_st_e_t cur;
    line_st_e_t nxt;
    out_item_t  res;
    logic       stable;
    logic       bad;
    cur    = shadow_lines[req.line_index];
    nxt    = cur;
    res    = '0;
    bad    = 1'b0;
    stable = (cur == ST_S) || (cur == ST_E) || (cur == ST_M);
    res.action = ACT_NONE;
    case (req.req_type)
      REQ_RD_MISS: begin
        if (cur == ST_I) begin
          nxt = ST_RD;
          res.action = ACT_RD_MISS;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (cur == ST_S) begin
          nxt = ST_WR;
          res.action = ACT_INVAL;
        end else if (cur == ST_I) begin
          nxt = ST_WR;
          res.action = ACT_WR_MISS;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_MAKE_DIRTY: begin
        if (stable) nxt = ST_M;
        else bad = 1'b1;
      end
      REQ_PREINVAL: begin
        if (cur == ST_M) nxt = ST_INV_D;
        else if (cur == ST_S || cur == ST_E) nxt = ST_INV;
        else bad = 1'b1;
      end
      REQ_SNP_RD, REQ_SNP_WR, REQ_SNP_INV: begin
        // Snoops merge the response with a stable local copy.
        res.action       = ACT_ACK;
        res.merged_state = req.resp_state;
        res.merged_found = req.resp_found;
        if (stable) begin
          if (cur == ST_S) begin
            if (!req.resp_found) begin
              res.merged_found = 1'b1;
              res.is_supplier  = 1'b1;
              res.merged_state = RESP_S;
            end
          end else begin
            res.merged_found = 1'b1;
            res.is_supplier  = 1'b1;
            res.merged_state = (cur == ST_M) ? RESP_M : RESP_E;
            res.write_down   = (cur == ST_M);
          end
          nxt = (req.req_type == REQ_SNP_RD) ? ST_S : ST_I;
        end
      end
      REQ_RD_ACK: begin
        if (req.resp_state == RESP_I && cur == ST_RD) begin
          nxt = ST_RD_MEM;
          res.action = ACT_RESEND;
        end else if (req.resp_state == RESP_I && cur == ST_RD_MEM) begin
          nxt = ST_E;
          res.action = ACT_CONCLUDE;
        end else if (req.resp_state != RESP_I && cur == ST_RD) begin
          nxt = ST_S;
          res.action = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_WR_ACK: begin
        if (req.resp_state == RESP_I && cur == ST_WR) begin
          nxt = ST_WR_MEM;
          res.action = ACT_RESEND;
        end else if (cur == ST_WR || cur == ST_WR_MEM) begin
          nxt = ST_M;
          res.action = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      REQ_INV_ACK: begin
        if (cur == ST_WR) begin
          nxt = ST_M;
          res.action = ACT_CONCLUDE;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nxt        = cur;
      res.action = ACT_NONE;
    end
    res.illegal = bad;
    res.new_state = nxt;
    shadow_lines[req.line_index] = nxt;
    return res;
  endfunction

  // Builds a request that the line's current state accepts, with random
  // response fields wherever they do not decide the transition.
  function automatic in_item_t pick_legal_request(logic [9:0] idx);
    in_item_t    req;
    int unsigned roll;
    req.line_index = idx;
    req.resp_state = 2'($urandom_range(0, 3));
    req.resp_found = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    req.req_type = REQ_SNP_RD + 4'($urandom_range(0, 2));
    case (shadow_lines[idx])
      ST_I: begin
        if (roll < 45) req.req_type = REQ_RD_MISS;
        else if (roll < 75) req.req_type = REQ_WRITE;
      end
      ST_S: begin
        if (roll < 30) req.req_type = REQ_WRITE;
        else if (roll < 50) req.req_type = REQ_MAKE_DIRTY;
        else if (roll < 55) req.req_type = REQ_PREINVAL;
      end
      ST_E, ST_M: begin
        if (roll < 30) req.req_type = REQ_MAKE_DIRTY;
        else if (roll < 36) req.req_type = REQ_PREINVAL;
      end
      ST_RD: begin
        if (roll < 85) req.req_type = REQ_RD_ACK;
        if (roll < 40) req.resp_state = RESP_I;
      end
      ST_RD_MEM: begin
        if (roll < 85) begin
          req.req_type   = REQ_RD_ACK;
          req.resp_state = RESP_I;
        end
      end
      ST_WR: begin
        if (roll < 45) req.req_type = REQ_WR_ACK;
        else if (roll < 85) req.req_type = REQ_INV_ACK;
        if (roll < 25) req.resp_state = RESP_I;
      end
      ST_WR_MEM: begin
        if (roll < 85) req.req_type = REQ_WR_ACK;
      end
      default: ;
    endcase
    return req;
  endfunction

  // Presents one request after the given idle gap and returns at the edge
  // that accepts it.
  task automatic send_request(in_item_t req, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    n_items++;
  endtask

  // Reports one result field that differs from its prediction.
  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Result checker: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("action",       4'(want.action),       4'(out_item.action));
        check_field("new_state",    want.new_state,        out_item.new_state);
        check_field("merged_state", 4'(want.merged_state), 4'(out_item.merged_state));
        check_field("merged_found", 4'(want.merged_found), 4'(out_item.merged_found));
        check_field("is_supplier",  4'(want.is_supplier),  4'(out_item.is_supplier));
        check_field("write_down",   4'(want.write_down),   4'(out_item.write_down));
        check_field("illegal",      4'(want.illegal),      4'(out_item.illegal));
        n_checked++;
        if (out_item.illegal) n_illegal++;
        if (out_item.is_supplier) n_supplied++;
        if (out_item.write_down) n_writeback++;
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    in_item_t    req;
    out_item_t   predicted;
    int unsigned gap;
    int unsigned idle_mode;
    int unsigned waited;

    for (int i = 0; i < NUM_LINES; i++) shadow_lines[i] = ST_I;

    // Layout: request type, line, response state, response found, typed flag,
    // then action, new state, merged state, found, supplier, write-back,
    // illegal.
    dir_rows = '{
      // Read miss on a freshly reset line.
      {REQ_RD_MISS, 10'd0, RESP_I, 1'b0, 1'b1, ACT_RD_MISS, ST_RD, RESP_I, 4'b0000},
      // Two-step read fill from memory, then a snoop, a dirtying write and an invalidating snoop.
      {REQ_RD_ACK, 10'd0, RESP_I, 1'b1, 1'b0, 13'd0},
      {REQ_RD_ACK, 10'd0, RESP_I, 1'b0, 1'b0, 13'd0},
      {REQ_SNP_RD, 10'd0, RESP_M, 1'b0, 1'b0, 13'd0},
      {REQ_MAKE_DIRTY, 10'd0, RESP_I, 1'b0, 1'b0, 13'd0},
      {REQ_SNP_INV, 10'd0, RESP_I, 1'b1, 1'b0, 13'd0},
      // Write miss on the top line, filled from memory, then a preinvalidate, an illegal read miss and a snoop.
      {REQ_WRITE, 10'd1023, RESP_M, 1'b1, 1'b1, ACT_WR_MISS, ST_WR, RESP_I, 4'b0000},
      {REQ_WR_ACK, 10'd1023, RESP_I, 1'b0, 1'b0, 13'd0},
      {REQ_WR_ACK, 10'd1023, RESP_S, 1'b1, 1'b0, 13'd0},
      {REQ_PREINVAL, 10'd1023, RESP_E, 1'b0, 1'b0, 13'd0},
      {REQ_RD_MISS, 10'd1023, RESP_I, 1'b0, 1'b1, ACT_NONE, ST_INV_D, RESP_I, 4'b0001},
      {REQ_SNP_WR, 10'd1023, RESP_E, 1'b1, 1'b0, 13'd0},
      // Shared fill, snoops with and without a prior finder, upgrade, preinvalidate.
      {REQ_RD_MISS, 10'd5, RESP_I, 1'b0, 1'b0, 13'd0},
      {REQ_RD_ACK, 10'd5, RESP_S, 1'b1, 1'b0, 13'd0},
      {REQ_SNP_RD, 10'd5, RESP_I, 1'b1, 1'b0, 13'd0},
      {REQ_SNP_RD, 10'd5, RESP_S, 1'b0, 1'b0, 13'd0},
      {REQ_WRITE, 10'd5, RESP_I, 1'b0, 1'b0, 13'd0},
      {REQ_INV_ACK, 10'd5, RESP_M, 1'b0, 1'b0, 13'd0},
      {REQ_PREINVAL, 10'd5, RESP_I, 1'b1, 1'b0, 13'd0},
      // Illegal requests on invalid lines, undefined request codes included, and a snoop on an invalid line.
      {REQ_MAKE_DIRTY, 10'd6, RESP_I, 1'b0, 1'b1, ACT_NONE, ST_I, RESP_I, 4'b0001},
      {REQ_UNDEF_HI, 10'd7, RESP_M, 1'b1, 1'b1, ACT_NONE, ST_I, RESP_I, 4'b0001},
      {REQ_UNDEF_LO, 10'd7, RESP_S, 1'b0, 1'b1, ACT_NONE, ST_I, RESP_I, 4'b0001},
      {REQ_SNP_WR, 10'd2, RESP_M, 1'b0, 1'b0, 13'd0},
      {REQ_INV_ACK, 10'd2, RESP_I, 1'b0, 1'b1, ACT_NONE, ST_I, RESP_I, 4'b0001},
      {REQ_WR_ACK, 10'd3, RESP_M, 1'b1, 1'b1, ACT_NONE, ST_I, RESP_I, 4'b0001}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows still advance the shadow table.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].item, $urandom_range(0, 2));
      predicted = apply_coherence(dir_rows[i].item);
      pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
    end

    // Random traffic, mostly legal sequences on a small set of busy lines.
    idle_mode = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        foreach (hot_lines[k]) hot_lines[k] = 10'($urandom_range(0, NUM_LINES - 1));
        idle_mode = $urandom_range(0, 2);
      end
      if ($urandom_range(0, 9) < 7) req = pick_legal_request(hot_lines[$urandom_range(0, POOL_SIZE - 1)]);
      else req = pick_legal_request(10'($urandom_range(0, NUM_LINES - 1)));
      if ($urandom_range(0, 9) < 2) req.req_type = 4'($urandom_range(0, 15));
      case (idle_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, MAX_GAP);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
      send_request(req, gap);
      pending_results.push_back(apply_coherence(req));
    end
    start <= 1'b0;

    // Wait for the last results, then idle before the summary.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, pending_results.size());
      n_errors++;
    end
    repeat (4) @(posedge clk);

    $display("Run summary: %0d requests sent, %0d results checked, %0d illegal.",
             n_items, n_checked, n_illegal);
    $display("Snoops answered with this cache as supplier: %0d, with write-back: %0d.",
             n_supplied, n_writeback);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
